### src/dsps_pkg.sv
// dsps_pkg: shared types and constants of the disk sector position sequencer
`default_nettype none
package dsps_pkg;

  localparam int unsigned POS_W    = 12;
  localparam int unsigned CYL_W    = 11;
  localparam int unsigned GEOM_W   = 6;
  localparam int unsigned SBYTES_W = 10;
  localparam int unsigned OFFSET_W = 31;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // multiply-add unit: a * b + c
  localparam int unsigned MAC_A_W = 25;
  localparam int unsigned MAC_B_W = 10;
  localparam int unsigned MAC_C_W = 12;
  localparam int unsigned MAC_P_W = 35;

  localparam logic [CYL_W-1:0]    LAST_CYL_RESET     = 11'd410;
  localparam logic [GEOM_W-1:0]   TRACKS_RESET       = 6'd19;
  localparam logic [GEOM_W-1:0]   SECTORS_RESET      = 6'd24;
  localparam logic [SBYTES_W-1:0] SECTOR_BYTES_RESET = 10'd512;
  localparam logic [POS_W-1:0]    DEADSTART_SECTOR   = 12'd3;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX         = {OFFSET_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAST_CYLINDER = 2'd0,
    REG_TRACKS        = 2'd1,
    REG_SECTORS       = 2'd2,
    REG_SECTOR_BYTES  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_SEEK      = 2'd0,
    OP_CHECK     = 2'd1,
    OP_ADVANCE   = 2'd2,
    OP_DEADSTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CYLINDER = 2'd1,
    ST_BAD_TRACK    = 2'd2,
    ST_BAD_SECTOR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_MUL2,
    S_MUL3,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

### src/dsps_if.sv
// dsps_if: input and output channel interfaces
`default_nettype none
interface dsps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] new_cylinder;
  logic [11:0] new_track;
  logic [11:0] new_sector;
  logic        half_interlace;
  logic        is_write;

  modport source (output valid, op, new_cylinder, new_track, new_sector, half_interlace,
                  is_write, input ready);
  modport sink   (input valid, op, new_cylinder, new_track, new_sector, half_interlace,
                  is_write, output ready);
endinterface

interface dsps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [30:0] byte_offset;
  logic        repositioned;
  logic [11:0] cur_cylinder;
  logic [11:0] cur_track;
  logic [11:0] cur_sector;

  modport source (output valid, status, byte_offset, repositioned, cur_cylinder, cur_track,
                  cur_sector, input ready);
  modport sink   (input valid, status, byte_offset, repositioned, cur_cylinder, cur_track,
                  cur_sector, output ready);
endinterface
`default_nettype wire

### src/dsps_mac.sv
// dsps_mac: shared multiply-add unit for the linear offset
`default_nettype none
module dsps_mac (
  input  wire logic [dsps_pkg::MAC_A_W-1:0] a,
  input  wire logic [dsps_pkg::MAC_B_W-1:0] b,
  input  wire logic [dsps_pkg::MAC_C_W-1:0] c,
  output logic      [dsps_pkg::MAC_P_W-1:0] p
);

  logic [dsps_pkg::MAC_P_W-1:0] prod;

  assign prod = dsps_pkg::MAC_P_W'(a) * dsps_pkg::MAC_P_W'(b);
  assign p    = prod + dsps_pkg::MAC_P_W'(c);

endmodule
`default_nettype wire

### src/disk_sector_position_sequencer_top.sv
// disk_sector_position_sequencer_top: disk position keeper with offset check
// One word in gives one word out. Advance goes from the update state (EXEC) to the
// load state (DONE). Seek, transfer check and deadstart take an update state, a
// compare state that also starts the offset, then two more passes through the one
// shared multiply-add unit ((cylinder*tracks + track)*sectors + sector)*sector_bytes,
// and a state that loads the result. An invalid position skips the two passes.
// Input is not ready until the result is loaded, so a new word is taken only after the
// last one is through, and the load waits while the output is full. The result
// register holds the result until taken while the next word is accepted.
`default_nettype none
module disk_sector_position_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [dsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsps_pkg::CFG_W-1:0]     cfg_data,
  dsps_in_if.sink          in_ch,
  dsps_out_if.source       out_ch
);

  dsps_pkg::seq_state_t state, state_next;

  logic [dsps_pkg::CYL_W-1:0]    last_cyl;
  logic [dsps_pkg::GEOM_W-1:0]   tracks;
  logic [dsps_pkg::GEOM_W-1:0]   sectors;
  logic [dsps_pkg::SBYTES_W-1:0] sector_bytes;

  logic [dsps_pkg::POS_W-1:0] pos_cyl, pos_track, pos_sector;
  logic interlace_two, pending, last_was_write;

  dsps_pkg::op_t op_q;
  logic [dsps_pkg::POS_W-1:0] new_cyl_q, new_track_q, new_sector_q;
  logic half_q, wr_q;

  logic [dsps_pkg::MAC_P_W-1:0] acc;
  dsps_pkg::status_t res_status;
  logic res_rep;

  logic out_valid;
  dsps_pkg::status_t out_status;
  logic [dsps_pkg::OFFSET_W-1:0] out_offset;
  logic out_rep;
  logic [dsps_pkg::POS_W-1:0] out_cyl, out_track, out_sector;

  logic [dsps_pkg::MAC_A_W-1:0] mac_a;
  logic [dsps_pkg::MAC_B_W-1:0] mac_b;
  logic [dsps_pkg::MAC_C_W-1:0] mac_c;
  logic [dsps_pkg::MAC_P_W-1:0] mac_p;

  logic accept, out_free, pos_valid, dir;
  logic cyl_bad, track_bad, sector_bad;
  logic [dsps_pkg::POS_W-1:0] adv_cyl, adv_track, adv_sector;
  logic [dsps_pkg::POS_W-1:0] s1, s2, t1;
  logic [dsps_pkg::POS_W-1:0] spt_ext, spt_plus1, tpc_ext;
  logic [dsps_pkg::OFFSET_W-1:0] sat_offset;

  assign accept   = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid | out_ch.ready;
  assign in_ch.ready = (state == dsps_pkg::S_IDLE);

  assign dir        = (op_q == dsps_pkg::OP_CHECK) ? wr_q : 1'b0;
  assign cyl_bad    = pos_cyl > {1'b0, last_cyl};
  assign tpc_ext    = {{(dsps_pkg::POS_W-dsps_pkg::GEOM_W){1'b0}}, tracks};
  assign spt_ext    = {{(dsps_pkg::POS_W-dsps_pkg::GEOM_W){1'b0}}, sectors};
  assign spt_plus1  = spt_ext + 12'd1;
  assign track_bad  = pos_track >= tpc_ext;
  assign sector_bad = pos_sector >= spt_ext;
  assign pos_valid  = ~cyl_bad & ~track_bad & ~sector_bad;

  // next sector under the interlace wrap rules
  assign s1 = pos_sector + 12'd1;
  assign s2 = pos_sector + 12'd2;
  assign t1 = pos_track + 12'd1;

  always_comb begin
    adv_cyl    = pos_cyl;
    adv_track  = pos_track;
    adv_sector = pos_sector;
    if (!interlace_two) begin
      adv_sector = s1;
      if (s1 == spt_ext) begin
        adv_sector = '0;
        adv_track  = t1;
      end
    end else begin
      adv_sector = s2;
      if (s2 == spt_ext) begin
        adv_sector = '0;
        adv_track  = t1;
        if (t1 == tpc_ext) begin
          adv_track  = '0;
          adv_sector = 12'd1;
        end
      end else if (s2 == spt_plus1) begin
        adv_sector = 12'd1;
        adv_track  = t1;
      end
    end
  end

  always_comb begin
    case (state)
      dsps_pkg::S_CHECK: begin
        mac_a = dsps_pkg::MAC_A_W'(pos_cyl);
        mac_b = dsps_pkg::MAC_B_W'(tracks);
        mac_c = pos_track;
      end
      dsps_pkg::S_MUL2: begin
        mac_a = acc[dsps_pkg::MAC_A_W-1:0];
        mac_b = dsps_pkg::MAC_B_W'(sectors);
        mac_c = pos_sector;
      end
      default: begin
        mac_a = acc[dsps_pkg::MAC_A_W-1:0];
        mac_b = sector_bytes;
        mac_c = '0;
      end
    endcase
  end

  dsps_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .p (mac_p)
  );

  assign sat_offset = (acc[dsps_pkg::MAC_P_W-1:dsps_pkg::OFFSET_W] != '0) ?
                      dsps_pkg::OFFSET_MAX : acc[dsps_pkg::OFFSET_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dsps_pkg::S_IDLE:  if (accept) state_next = dsps_pkg::S_EXEC;
      dsps_pkg::S_EXEC:  state_next = (op_q == dsps_pkg::OP_ADVANCE) ? dsps_pkg::S_DONE
                                                                   : dsps_pkg::S_CHECK;
      dsps_pkg::S_CHECK: state_next = pos_valid ? dsps_pkg::S_MUL2 : dsps_pkg::S_DONE;
      dsps_pkg::S_MUL2:  state_next = dsps_pkg::S_MUL3;
      dsps_pkg::S_MUL3:  state_next = dsps_pkg::S_DONE;
      dsps_pkg::S_DONE:  if (out_free) state_next = dsps_pkg::S_IDLE;
      default:           state_next = dsps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cyl       <= dsps_pkg::LAST_CYL_RESET;
      tracks         <= dsps_pkg::TRACKS_RESET;
      sectors        <= dsps_pkg::SECTORS_RESET;
      sector_bytes   <= dsps_pkg::SECTOR_BYTES_RESET;
      pos_cyl        <= '0;
      pos_track      <= '0;
      pos_sector     <= '0;
      interlace_two  <= 1'b0;
      pending        <= 1'b1;
      last_was_write <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (dsps_pkg::cfg_index_t'(cfg_index))
          dsps_pkg::REG_LAST_CYLINDER: last_cyl <= cfg_data[dsps_pkg::CYL_W-1:0];
          dsps_pkg::REG_TRACKS:        tracks <= cfg_data[dsps_pkg::GEOM_W-1:0];
          dsps_pkg::REG_SECTORS:       sectors <= cfg_data[dsps_pkg::GEOM_W-1:0];
          dsps_pkg::REG_SECTOR_BYTES:  sector_bytes <= cfg_data[dsps_pkg::SBYTES_W-1:0];
          default: ;
        endcase
      end

      if (state == dsps_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        dsps_pkg::S_EXEC: begin
          res_status <= dsps_pkg::ST_OK;
          res_rep    <= 1'b0;
          acc        <= '0;
          case (op_q)
            dsps_pkg::OP_SEEK: begin
              interlace_two <= half_q;
              if (new_cyl_q != pos_cyl || new_track_q != pos_track ||
                  new_sector_q != pos_sector) pending <= 1'b1;
              pos_cyl    <= new_cyl_q;
              pos_track  <= new_track_q;
              pos_sector <= new_sector_q;
            end
            dsps_pkg::OP_ADVANCE: begin
              pos_cyl    <= adv_cyl;
              pos_track  <= adv_track;
              pos_sector <= adv_sector;
              if (interlace_two) pending <= 1'b1;
            end
            dsps_pkg::OP_DEADSTART: begin
              pos_cyl    <= {1'b0, last_cyl};
              pos_track  <= '0;
              pos_sector <= dsps_pkg::DEADSTART_SECTOR;
              pending    <= 1'b1;
            end
            default: ;
          endcase
        end
        dsps_pkg::S_CHECK: begin
          if (cyl_bad) begin
            res_status <= dsps_pkg::ST_BAD_CYLINDER;
          end else if (track_bad) begin
            res_status <= dsps_pkg::ST_BAD_TRACK;
          end else if (sector_bad) begin
            res_status <= dsps_pkg::ST_BAD_SECTOR;
          end else begin
            acc            <= mac_p;
            res_rep        <= pending | (last_was_write != dir);
            pending        <= 1'b0;
            last_was_write <= dir;
          end
        end
        dsps_pkg::S_MUL2, dsps_pkg::S_MUL3: begin
          acc <= mac_p;
        end
        default: ;
      endcase
    end
  end

  // payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q         <= dsps_pkg::op_t'(in_ch.op);
      new_cyl_q    <= in_ch.new_cylinder;
      new_track_q  <= in_ch.new_track;
      new_sector_q <= in_ch.new_sector;
      half_q       <= in_ch.half_interlace;
      wr_q         <= in_ch.is_write;
    end
    if (state == dsps_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_offset <= sat_offset;
      out_rep    <= res_rep;
      out_cyl    <= pos_cyl;
      out_track  <= pos_track;
      out_sector <= pos_sector;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.byte_offset  = out_offset;
  assign out_ch.repositioned = out_rep;
  assign out_ch.cur_cylinder = out_cyl;
  assign out_ch.cur_track    = out_track;
  assign out_ch.cur_sector   = out_sector;

endmodule
`default_nettype wire

### src/dsps_checker.sv
// dsps_checker: port-level assertions for the sequencer, bound to the top level
`default_nettype none
module dsps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [30:0] byte_offset,
  input wire logic        repositioned,
  input wire logic [11:0] cur_sector
);

  // a result word waits with its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_offset)
                                && $stable(cur_sector))
    else $error("result word dropped or changed while stalled");

  // one word at a time: busy straight after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a failed check gives no offset and no reposition
  a_bad_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dsps_pkg::ST_OK |-> byte_offset == '0 && !repositioned)
    else $error("offset or reposition on invalid position");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind disk_sector_position_sequencer_top dsps_checker u_dsps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .byte_offset  (out_ch.byte_offset),
  .repositioned (out_ch.repositioned),
  .cur_sector   (out_ch.cur_sector)
);
`default_nettype wire

### sim/disk_sector_position_sequencer_top_test.sv
// disk_sector_position_sequencer_top_test: self-checking bench for the disk position sequencer
module disk_sector_position_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 150;

  typedef struct packed {
    dsps_pkg::op_t              op;
    logic [dsps_pkg::POS_W-1:0] cyl;
    logic [dsps_pkg::POS_W-1:0] trk;
    logic [dsps_pkg::POS_W-1:0] sec;
    logic                       half;
    logic                       wr;
  } disk_cmd_t;

  typedef struct packed {
    dsps_pkg::status_t             status;
    logic [dsps_pkg::OFFSET_W-1:0] offset;
    logic                          repos;
    logic [dsps_pkg::POS_W-1:0]    cyl;
    logic [dsps_pkg::POS_W-1:0]    trk;
    logic [dsps_pkg::POS_W-1:0]    sec;
  } disk_pos_t;

  typedef struct packed {
    bit                         is_cfg;
    dsps_pkg::cfg_index_t       idx;
    logic [dsps_pkg::CFG_W-1:0] data;
    disk_cmd_t                  cmd;
    bit                         typed;
    disk_pos_t                  want;
  } plan_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [dsps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dsps_pkg::CFG_W-1:0]     cfg_data;

  dsps_in_if  in_ch ();
  dsps_out_if out_ch ();

  disk_sector_position_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // geometry and position as the block should hold them
  logic [dsps_pkg::CYL_W-1:0]    geo_last_cyl = dsps_pkg::LAST_CYL_RESET;
  logic [dsps_pkg::GEOM_W-1:0]   geo_tracks   = dsps_pkg::TRACKS_RESET;
  logic [dsps_pkg::GEOM_W-1:0]   geo_sectors  = dsps_pkg::SECTORS_RESET;
  logic [dsps_pkg::SBYTES_W-1:0] geo_bytes    = dsps_pkg::SECTOR_BYTES_RESET;
  logic [dsps_pkg::POS_W-1:0]    pos_cyl      = '0;
  logic [dsps_pkg::POS_W-1:0]    pos_trk      = '0;
  logic [dsps_pkg::POS_W-1:0]    pos_sec      = '0;
  logic                          interlace_two = 1'b0;
  logic                          seek_pending  = 1'b1;
  logic                          last_write    = 1'b0;

  disk_pos_t positions_due[$];
  plan_row_t plan[$];
  int        fail_count = 0;
  bit        steady = 1'b0;
  bit        stall_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic disk_pos_t transfer_check(input logic wr);
    disk_pos_t   r;
    logic [63:0] lin;
    r = '0;
    if (pos_cyl > dsps_pkg::POS_W'(geo_last_cyl)) begin
      r.status = dsps_pkg::ST_BAD_CYLINDER;
    end else if (pos_trk >= dsps_pkg::POS_W'(geo_tracks)) begin
      r.status = dsps_pkg::ST_BAD_TRACK;
    end else if (pos_sec >= dsps_pkg::POS_W'(geo_sectors)) begin
      r.status = dsps_pkg::ST_BAD_SECTOR;
    end else begin
      lin = 64'(pos_cyl) * 64'(geo_tracks) + 64'(pos_trk);
      lin = lin * 64'(geo_sectors) + 64'(pos_sec);
      lin = lin * 64'(geo_bytes);
      r.offset = (lin > 64'(dsps_pkg::OFFSET_MAX)) ? dsps_pkg::OFFSET_MAX
                                                   : lin[dsps_pkg::OFFSET_W-1:0];
      if (seek_pending || last_write != wr) begin
        r.repos = 1'b1;
        seek_pending = 1'b0;
        last_write = wr;
      end
    end
    return r;
  endfunction

  function automatic disk_pos_t next_position(input disk_cmd_t c);
    disk_pos_t r;
    r = '0;
    case (c.op)
      dsps_pkg::OP_SEEK: begin
        interlace_two = c.half;
        if (c.cyl != pos_cyl || c.trk != pos_trk || c.sec != pos_sec)
          seek_pending = 1'b1;
        pos_cyl = c.cyl;
        pos_trk = c.trk;
        pos_sec = c.sec;
        r = transfer_check(1'b0);
      end
      dsps_pkg::OP_CHECK: r = transfer_check(c.wr);
      dsps_pkg::OP_ADVANCE: begin
        if (!interlace_two) begin
          pos_sec = pos_sec + 1'b1;
          if (pos_sec == dsps_pkg::POS_W'(geo_sectors)) begin
            pos_sec = '0;
            pos_trk = pos_trk + 1'b1;
          end
        end else begin
          pos_sec = pos_sec + 2'd2;
          seek_pending = 1'b1;
          if (pos_sec == dsps_pkg::POS_W'(geo_sectors)) begin
            pos_sec = '0;
            pos_trk = pos_trk + 1'b1;
            if (pos_trk == dsps_pkg::POS_W'(geo_tracks)) begin
              pos_trk = '0;
              pos_sec = 12'd1;
            end
          end else if (pos_sec == dsps_pkg::POS_W'(geo_sectors) + 12'd1) begin
            pos_sec = 12'd1;
            pos_trk = pos_trk + 1'b1;
          end
        end
      end
      default: begin
        pos_cyl = dsps_pkg::POS_W'(geo_last_cyl);
        pos_trk = '0;
        pos_sec = dsps_pkg::DEADSTART_SECTOR;
        seek_pending = 1'b1;
        r = transfer_check(1'b0);
      end
    endcase
    r.cyl = pos_cyl;
    r.trk = pos_trk;
    r.sec = pos_sec;
    return r;
  endfunction

  function automatic disk_cmd_t random_word();
    disk_cmd_t c;
    int        pick;
    int        shape;
    c.cyl  = dsps_pkg::POS_W'($urandom);
    c.trk  = dsps_pkg::POS_W'($urandom);
    c.sec  = dsps_pkg::POS_W'($urandom);
    c.half = 1'($urandom);
    c.wr   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.op = dsps_pkg::OP_SEEK;
      shape = $urandom_range(0, 99);
      if (shape < 70) begin
        c.cyl = dsps_pkg::POS_W'($urandom_range(0, geo_last_cyl));
        c.trk = (geo_tracks == 0) ? dsps_pkg::POS_W'($urandom_range(0, 3))
                                  : dsps_pkg::POS_W'($urandom_range(0, geo_tracks - 1));
        c.sec = (geo_sectors == 0) ? dsps_pkg::POS_W'($urandom_range(0, 3))
                                   : dsps_pkg::POS_W'($urandom_range(0, geo_sectors - 1));
      end else if (shape < 85) begin
        c.cyl = dsps_pkg::POS_W'(geo_last_cyl) + dsps_pkg::POS_W'($urandom_range(0, 1));
        c.trk = dsps_pkg::POS_W'(geo_tracks) - dsps_pkg::POS_W'($urandom_range(0, 1));
        c.sec = dsps_pkg::POS_W'(geo_sectors) - dsps_pkg::POS_W'($urandom_range(0, 1));
      end
    end else if (pick < 60) begin
      c.op = dsps_pkg::OP_CHECK;
    end else if (pick < 90) begin
      c.op = dsps_pkg::OP_ADVANCE;
    end else begin
      c.op = dsps_pkg::OP_DEADSTART;
    end
    return c;
  endfunction

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_geometry(input dsps_pkg::cfg_index_t idx,
                               input logic [dsps_pkg::CFG_W-1:0] data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      dsps_pkg::REG_LAST_CYLINDER: geo_last_cyl = data[dsps_pkg::CYL_W-1:0];
      dsps_pkg::REG_TRACKS:        geo_tracks   = data[dsps_pkg::GEOM_W-1:0];
      dsps_pkg::REG_SECTORS:       geo_sectors  = data[dsps_pkg::GEOM_W-1:0];
      default:                     geo_bytes    = data[dsps_pkg::SBYTES_W-1:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic issue_word(input disk_cmd_t c, input bit typed, input disk_pos_t want);
    disk_pos_t calc;
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= c.op;
    in_ch.new_cylinder   <= c.cyl;
    in_ch.new_track      <= c.trk;
    in_ch.new_sector     <= c.sec;
    in_ch.half_interlace <= c.half;
    in_ch.is_write       <= c.wr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    calc = next_position(c);
    positions_due.push_back(typed ? want : calc);
  endtask

  task automatic set_geometry(input int phase);
    int lc;
    int tr;
    int sc;
    int sb;
    case (phase)
      0: begin lc = 2047; tr = 63; sc = 63; sb = 1023; end
      1: begin lc = 0;    tr = 1;  sc = 1;  sb = 1;    end
      2: begin lc = 410;  tr = 19; sc = 24; sb = 512;  end
      3: begin lc = 3;    tr = 4;  sc = 5;  sb = 644;  end
      4: begin lc = 7;    tr = 0;  sc = 5;  sb = 0;    end
      5: begin lc = 6;    tr = 3;  sc = 0;  sb = 100;  end
      default: begin
        lc = $urandom_range(0, 20);
        tr = $urandom_range(1, 9);
        sc = $urandom_range(1, 9);
        sb = $urandom_range(0, 1023);
      end
    endcase
    load_geometry(dsps_pkg::REG_LAST_CYLINDER, dsps_pkg::CFG_W'(lc));
    load_geometry(dsps_pkg::REG_TRACKS, {5'($urandom), 6'(tr)});
    load_geometry(dsps_pkg::REG_SECTORS, {5'($urandom), 6'(sc)});
    load_geometry(dsps_pkg::REG_SECTOR_BYTES, {1'($urandom), 10'(sb)});
  endtask

  function automatic void add_word(input disk_cmd_t c, input bit typed, input disk_pos_t want);
    plan_row_t r;
    r = '0;
    r.cmd = c;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input dsps_pkg::cfg_index_t idx,
                                  input logic [dsps_pkg::CFG_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  // result side: ready with random gaps, one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    disk_pos_t got;
    disk_pos_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status = dsps_pkg::status_t'(out_ch.status);
        got.offset = out_ch.byte_offset;
        got.repos  = out_ch.repositioned;
        got.cyl    = out_ch.cur_cylinder;
        got.trk    = out_ch.cur_track;
        got.sec    = out_ch.cur_sector;
        if (positions_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = positions_due.pop_front();
          compare_field("status", out_ch.status, want.status);
          compare_field("byte_offset", out_ch.byte_offset, want.offset);
          compare_field("repositioned", out_ch.repositioned, want.repos);
          compare_field("cur_cylinder", got.cyl, want.cyl);
          compare_field("cur_track", got.trk, want.trk);
          compare_field("cur_sector", got.sec, want.sec);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dsps_pkg::REG_LAST_CYLINDER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = dsps_pkg::OP_SEEK;
    in_ch.new_cylinder = '0;
    in_ch.new_track = '0;
    in_ch.new_sector = '0;
    in_ch.half_interlace = 1'b0;
    in_ch.is_write = 1'b0;

    // out of reset, direction change, deadstart, each invalid coordinate
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_OK, 31'd0, 1'b1, 12'd0, 12'd0, 12'd0});
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_OK, 31'd0, 1'b0, 12'd0, 12'd0, 12'd0});
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 1,
             '{dsps_pkg::ST_OK, 31'd0, 1'b1, 12'd0, 12'd0, 12'd0});
    add_word('{dsps_pkg::OP_DEADSTART, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1}, 1,
             '{dsps_pkg::ST_OK, 31'd95725056, 1'b1, 12'd410, 12'd0, 12'd3});
    add_word('{dsps_pkg::OP_SEEK, 12'd411, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_BAD_CYLINDER, 31'd0, 1'b0, 12'd411, 12'd0, 12'd0});
    add_word('{dsps_pkg::OP_SEEK, 12'd0, 12'd19, 12'd0, 1'b0, 1'b1}, 1,
             '{dsps_pkg::ST_BAD_TRACK, 31'd0, 1'b0, 12'd0, 12'd19, 12'd0});
    add_word('{dsps_pkg::OP_SEEK, 12'd0, 12'd0, 12'd24, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_BAD_SECTOR, 31'd0, 1'b0, 12'd0, 12'd0, 12'd24});
    add_word('{dsps_pkg::OP_SEEK, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1}, 1,
             '{dsps_pkg::ST_BAD_CYLINDER, 31'd0, 1'b0, 12'd4095, 12'd4095, 12'd4095});
    add_word('{dsps_pkg::OP_ADVANCE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_OK, 31'd0, 1'b0, 12'd4095, 12'd4095, 12'd1});
    // wrap rules for both interlace modes
    add_word('{dsps_pkg::OP_SEEK, 12'd410, 12'd18, 12'd23, 1'b0, 1'b1}, 0, '0);
    add_word('{dsps_pkg::OP_ADVANCE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 0, '0);
    add_word('{dsps_pkg::OP_SEEK, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_ADVANCE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_SEEK, 12'd0, 12'd18, 12'd22, 1'b1, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_ADVANCE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 0, '0);
    add_word('{dsps_pkg::OP_SEEK, 12'd0, 12'd0, 12'd23, 1'b1, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_ADVANCE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 0, '0);
    add_word('{dsps_pkg::OP_SEEK, 12'd2, 12'd5, 12'd7, 1'b0, 1'b1}, 0, '0);
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 0, '0);
    add_word('{dsps_pkg::OP_CHECK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 0, '0);
    // largest geometry, offset saturates
    add_cfg(dsps_pkg::REG_LAST_CYLINDER, 11'd2047);
    add_cfg(dsps_pkg::REG_TRACKS, 11'd63);
    add_cfg(dsps_pkg::REG_SECTORS, 11'd63);
    add_cfg(dsps_pkg::REG_SECTOR_BYTES, 11'd1023);
    add_word('{dsps_pkg::OP_SEEK, 12'd2047, 12'd62, 12'd62, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_OK, dsps_pkg::OFFSET_MAX, 1'b1, 12'd2047, 12'd62, 12'd62});
    // smallest geometry
    add_cfg(dsps_pkg::REG_LAST_CYLINDER, 11'd0);
    add_cfg(dsps_pkg::REG_TRACKS, 11'd1);
    add_cfg(dsps_pkg::REG_SECTORS, 11'd1);
    add_cfg(dsps_pkg::REG_SECTOR_BYTES, 11'd1);
    add_word('{dsps_pkg::OP_SEEK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_OK, 31'd0, 1'b1, 12'd0, 12'd0, 12'd0});
    add_word('{dsps_pkg::OP_SEEK, 12'd1, 12'd0, 12'd0, 1'b0, 1'b0}, 1,
             '{dsps_pkg::ST_BAD_CYLINDER, 31'd0, 1'b0, 12'd1, 12'd0, 12'd0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        load_geometry(plan[i].idx, plan[i].data);
      else
        issue_word(plan[i].cmd, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_geometry(p);
      steady = (p == 6);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 2 && i == 20)
          stall_request = 1'b1;
        if (p == 3 && i == 75)
          drain_results();
        issue_word(random_word(), 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
src/dsps_pkg.sv
src/dsps_if.sv
src/dsps_mac.sv
src/disk_sector_position_sequencer_top.sv
src/dsps_checker.sv
sim/disk_sector_position_sequencer_top_test.sv
